FILE: hw/rtl/lmp_pkg.sv
// Shared types and constants of the landmark line parser.
`timescale 1ns / 1ps

package lmp_pkg;

    // Fraction digits kept in the bearing (hundredths by default).
    localparam int LMP_FRAC_DIGITS = 2;
    // Width of the decimal scale 10^LMP_FRAC_DIGITS.
    localparam int LMP_SCALE_W = $clog2((10 ** LMP_FRAC_DIGITS) + 1);
    // Depth of the queue between classifier and parser.
    localparam int LMP_QDEPTH = 2;
    localparam int LMP_QPTR_W = $clog2(LMP_QDEPTH);
    localparam int LMP_QCNT_W = $clog2(LMP_QDEPTH + 1);

    // Magnitude cap while digits accumulate.
    localparam logic [31:0] LMP_MAG_CAP = 32'h8000_0000;
    localparam logic [31:0] LMP_POS_MAX = 32'h7FFF_FFFF;

    // Character codes.
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UC_L  = 8'h4C;
    localparam logic [7:0] CH_UC_M  = 8'h4D;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_E  = 8'h65;
    localparam logic [7:0] CH_LC_G  = 8'h67;
    localparam logic [7:0] CH_LC_I  = 8'h69;
    localparam logic [7:0] CH_LC_N  = 8'h6E;
    localparam logic [7:0] CH_LC_P  = 8'h70;
    localparam logic [7:0] CH_LC_R  = 8'h72;
    localparam logic [7:0] CH_LC_X  = 8'h78;

    // One classified byte as it travels through the queue.
    typedef struct packed {
        logic       eol;
        logic       digit;
        logic       ws;
        logic       sign;
        logic       minus;
        logic       dot;
        logic [7:0] ch;
    } lmp_item_t;

    // Scale that appends k zero fraction digits.
    function automatic logic [LMP_SCALE_W-1:0] lmp_pow10(input logic [2:0] k);
        logic [LMP_SCALE_W-1:0] p;
        p = LMP_SCALE_W'(1);
        for (int i = 0; i < LMP_FRAC_DIGITS; i++)
        begin
            if (i < int'(k))
            begin
                p = LMP_SCALE_W'(p * 10);
            end
        end
        return p;
    endfunction

endpackage

FILE: hw/rtl/lmp_front.sv
// Front end: accepts bytes, applies the line length limit and classifies them.
`timescale 1ns / 1ps

module lmp_front #(
    parameter int MAX_LINE = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         rx_byte,
    input  logic               rx_valid,
    output logic               rx_ready,
    input  logic               q_full,
    output logic               q_push,
    output lmp_pkg::lmp_item_t q_item
);
    import lmp_pkg::*;

    localparam int LC_W = $clog2(MAX_LINE);

    logic [LC_W-1:0] count_reg;
    logic [LC_W-1:0] count_next;
    logic            accept;
    logic            is_eol;
    logic            keep;

    assign rx_ready = !q_full;
    assign accept   = rx_valid && rx_ready;
    assign is_eol   = (rx_byte == CH_LF) || (rx_byte == CH_CR);

    // A line end is passed on only for a non-empty line; other bytes only below the limit.
    assign keep   = is_eol ? (count_reg != '0) : (count_reg < LC_W'(MAX_LINE - 1));
    assign q_push = accept && keep;

    always_comb
    begin
        q_item.eol   = is_eol;
        q_item.digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
        q_item.ws    = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) ||
                       (rx_byte == CH_VT) || (rx_byte == CH_FF);
        q_item.sign  = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
        q_item.minus = (rx_byte == CH_MINUS);
        q_item.dot   = (rx_byte == CH_DOT);
        q_item.ch    = rx_byte;
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (is_eol)
            begin
                count_next = '0;
            end
            else if (keep)
            begin
                count_next = count_reg + LC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

FILE: hw/rtl/lmp_queue.sv
// Short queue of classified bytes between the front end and the parser.
`timescale 1ns / 1ps

module lmp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lmp_pkg::lmp_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output lmp_pkg::lmp_item_t head_item
);
    import lmp_pkg::*;

    lmp_item_t             mem [LMP_QDEPTH];
    logic [LMP_QPTR_W-1:0] wr_ptr_reg;
    logic [LMP_QPTR_W-1:0] wr_ptr_next;
    logic [LMP_QPTR_W-1:0] rd_ptr_reg;
    logic [LMP_QPTR_W-1:0] rd_ptr_next;
    logic [LMP_QCNT_W-1:0] count_reg;
    logic [LMP_QCNT_W-1:0] count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full       = (count_reg == LMP_QCNT_W'(LMP_QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LMP_QPTR_W'(LMP_QDEPTH - 1)) ? '0
                        : wr_ptr_reg + LMP_QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LMP_QPTR_W'(LMP_QDEPTH - 1)) ? '0
                        : rd_ptr_reg + LMP_QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + LMP_QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - LMP_QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/lmp_back.sv
// Back end: line parser state machine, number accumulation and result register.
`timescale 1ns / 1ps

module lmp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  lmp_pkg::lmp_item_t q_item,
    output logic               q_pop,
    output logic signed [31:0] landmark_id,
    output logic signed [31:0] bearing_centi,
    output logic signed [31:0] pixel_size,
    output logic               msg_valid,
    input  logic               msg_ready
);
    import lmp_pkg::*;

    localparam logic [3:0] PH_LM      = 4'd0;
    localparam logic [3:0] PH_ID_WS   = 4'd1;
    localparam logic [3:0] PH_ID_SIGN = 4'd2;
    localparam logic [3:0] PH_ID_DIG  = 4'd3;
    localparam logic [3:0] PH_LIT_B   = 4'd4;
    localparam logic [3:0] PH_B_WS    = 4'd5;
    localparam logic [3:0] PH_B_SIGN  = 4'd6;
    localparam logic [3:0] PH_B_INT   = 4'd7;
    localparam logic [3:0] PH_B_FRAC  = 4'd8;
    localparam logic [3:0] PH_LIT_PX  = 4'd9;
    localparam logic [3:0] PH_PX_WS   = 4'd10;
    localparam logic [3:0] PH_PX_SIGN = 4'd11;
    localparam logic [3:0] PH_PX_DIG  = 4'd12;
    localparam logic [3:0] PH_DONE    = 4'd13;

    localparam logic [1:0] OK_NONE = 2'd0;
    localparam logic [1:0] OK_ID   = 2'd1;
    localparam logic [1:0] OK_BOTH = 2'd2;

    localparam int PROD_W = 32 + LMP_SCALE_W;

    // Expected character of a literal at a position.
    function automatic logic [7:0] lit_char(input logic [3:0] ph, input logic [2:0] pos);
        logic [7:0] c;
        c = CH_COLON;
        if (ph == PH_LM)
        begin
            case (pos)
                3'd0:    c = CH_UC_L;
                3'd1:    c = CH_UC_M;
                default: c = CH_COLON;
            endcase
        end
        else if (ph == PH_LIT_B)
        begin
            case (pos)
                3'd0:    c = CH_LC_B;
                3'd1:    c = CH_LC_E;
                3'd2:    c = CH_LC_A;
                3'd3:    c = CH_LC_R;
                3'd4:    c = CH_LC_I;
                3'd5:    c = CH_LC_N;
                3'd6:    c = CH_LC_G;
                default: c = CH_COLON;
            endcase
        end
        else
        begin
            case (pos)
                3'd0:    c = CH_LC_P;
                3'd1:    c = CH_LC_X;
                default: c = CH_COLON;
            endcase
        end
        return c;
    endfunction

    // Magnitude to two's complement with saturation.
    function automatic logic [31:0] to_signed(input logic [31:0] mag, input logic neg);
        logic [31:0] r;
        if (neg)
        begin
            r = 32'd0 - mag;
        end
        else
        begin
            r = mag[31] ? LMP_POS_MAX : mag;
        end
        return r;
    endfunction

    logic [3:0]  phase_reg;
    logic [3:0]  phase_next;
    logic [2:0]  pos_reg;
    logic [2:0]  pos_next;
    logic [31:0] id_reg;
    logic [31:0] id_next;
    logic [31:0] brg_reg;
    logic [31:0] brg_next;
    logic [31:0] px_reg;
    logic [31:0] px_next;
    logic        neg_reg;
    logic        neg_next;
    logic        seen_reg;
    logic        seen_next;
    logic [1:0]  ok_reg;
    logic [1:0]  ok_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_id_reg;
    logic [31:0] out_brg_reg;
    logic [31:0] out_px_reg;

    logic [31:0]             digit_val;
    logic [31:0]             acc_src;
    logic [35:0]             acc_wide;
    logic [31:0]             acc_sat;
    logic [PROD_W-1:0]       brg_prod;
    logic [31:0]             brg_mag;
    logic [31:0]             brg_fin;
    logic [31:0]             id_fin;
    logic [31:0]             px_fin;
    logic                    lit_hit;
    logic                    brg_live;
    logic [31:0]             eol_id;
    logic [31:0]             eol_brg;
    logic [31:0]             eol_px;
    logic [1:0]              eol_ok;
    logic                    load_out;

    assign q_pop    = q_valid && (!q_item.eol || !out_valid_reg || msg_ready);
    assign load_out = q_pop && q_item.eol && (eol_ok == OK_BOTH);

    assign digit_val = {28'd0, q_item.ch[3:0]};

    // One shared multiply-by-ten accumulator for whichever number is active.
    always_comb
    begin
        if ((phase_reg == PH_B_INT) || (phase_reg == PH_B_FRAC))
        begin
            acc_src = brg_reg;
        end
        else if (phase_reg == PH_PX_DIG)
        begin
            acc_src = px_reg;
        end
        else
        begin
            acc_src = id_reg;
        end
    end

    assign acc_wide = ({4'd0, acc_src} << 3) + ({4'd0, acc_src} << 1) + {4'd0, digit_val};
    assign acc_sat  = (acc_wide > {4'd0, LMP_MAG_CAP}) ? LMP_MAG_CAP : acc_wide[31:0];

    // Missing fraction digits are appended as one scale; the cap absorbs any overflow.
    assign brg_prod = PROD_W'(brg_reg) *
                      PROD_W'(lmp_pow10(3'(LMP_FRAC_DIGITS) - pos_reg));
    assign brg_mag  = (brg_prod > PROD_W'(LMP_MAG_CAP)) ? LMP_MAG_CAP : brg_prod[31:0];
    assign brg_fin  = to_signed(brg_mag, neg_reg);
    assign id_fin   = to_signed(id_reg, neg_reg);
    assign px_fin   = to_signed(px_reg, neg_reg);

    assign lit_hit  = (q_item.ch == lit_char(phase_reg, pos_reg));
    assign brg_live = ((phase_reg == PH_B_INT) || (phase_reg == PH_B_FRAC)) && seen_reg;

    // Numbers still open at the line end are closed here.
    always_comb
    begin
        eol_id  = id_reg;
        eol_brg = brg_reg;
        eol_px  = px_reg;
        eol_ok  = ok_reg;
        if (phase_reg == PH_ID_DIG)
        begin
            eol_id = id_fin;
            eol_ok = OK_ID;
        end
        else if (brg_live)
        begin
            eol_brg = brg_fin;
            eol_ok  = OK_BOTH;
        end
        else if (phase_reg == PH_PX_DIG)
        begin
            eol_px = px_fin;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        id_next    = id_reg;
        brg_next   = brg_reg;
        px_next    = px_reg;
        neg_next   = neg_reg;
        seen_next  = seen_reg;
        ok_next    = ok_reg;
        if (q_pop && q_item.eol)
        begin
            phase_next = PH_LM;
            pos_next   = '0;
            id_next    = '0;
            brg_next   = '0;
            px_next    = '0;
            neg_next   = 1'b0;
            seen_next  = 1'b0;
            ok_next    = OK_NONE;
        end
        else if (q_pop)
        begin
            unique case (phase_reg)
                PH_LM:
                begin
                    if (lit_hit)
                    begin
                        pos_next = pos_reg + 3'd1;
                        if (pos_reg == 3'd2)
                        begin
                            phase_next = PH_ID_WS;
                            pos_next   = '0;
                            neg_next   = 1'b0;
                            seen_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_ID_WS:
                begin
                    if (q_item.ws)
                    begin
                        phase_next = PH_ID_WS;
                    end
                    else if (q_item.sign)
                    begin
                        neg_next   = q_item.minus;
                        phase_next = PH_ID_SIGN;
                    end
                    else if (q_item.digit)
                    begin
                        id_next    = digit_val;
                        seen_next  = 1'b1;
                        phase_next = PH_ID_DIG;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_ID_SIGN:
                begin
                    if (q_item.digit)
                    begin
                        id_next    = digit_val;
                        seen_next  = 1'b1;
                        phase_next = PH_ID_DIG;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_ID_DIG:
                begin
                    if (q_item.digit)
                    begin
                        id_next = acc_sat;
                    end
                    else
                    begin
                        // Close the id, then this byte is read as the start of the bearing literal.
                        id_next = id_fin;
                        ok_next = OK_ID;
                        pos_next = '0;
                        if (q_item.ws)
                        begin
                            phase_next = PH_LIT_B;
                        end
                        else if (q_item.ch == CH_LC_B)
                        begin
                            phase_next = PH_LIT_B;
                            pos_next   = 3'd1;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_LIT_B:
                begin
                    if ((pos_reg == 3'd0) && q_item.ws)
                    begin
                        phase_next = PH_LIT_B;
                    end
                    else if (lit_hit)
                    begin
                        pos_next = pos_reg + 3'd1;
                        if (pos_reg == 3'd7)
                        begin
                            phase_next = PH_B_WS;
                            pos_next   = '0;
                            neg_next   = 1'b0;
                            seen_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_B_WS:
                begin
                    if (q_item.ws)
                    begin
                        phase_next = PH_B_WS;
                    end
                    else if (q_item.sign)
                    begin
                        neg_next   = q_item.minus;
                        phase_next = PH_B_SIGN;
                    end
                    else if (q_item.digit)
                    begin
                        brg_next   = digit_val;
                        seen_next  = 1'b1;
                        phase_next = PH_B_INT;
                    end
                    else if (q_item.dot)
                    begin
                        phase_next = PH_B_FRAC;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_B_SIGN:
                begin
                    if (q_item.digit)
                    begin
                        brg_next   = digit_val;
                        seen_next  = 1'b1;
                        phase_next = PH_B_INT;
                    end
                    else if (q_item.dot)
                    begin
                        phase_next = PH_B_FRAC;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_B_INT:
                begin
                    if (q_item.digit)
                    begin
                        brg_next = acc_sat;
                    end
                    else if (q_item.dot)
                    begin
                        phase_next = PH_B_FRAC;
                    end
                    else
                    begin
                        brg_next = brg_fin;
                        ok_next  = OK_BOTH;
                        pos_next = '0;
                        if (q_item.ws)
                        begin
                            phase_next = PH_LIT_PX;
                        end
                        else if (q_item.ch == CH_LC_P)
                        begin
                            phase_next = PH_LIT_PX;
                            pos_next   = 3'd1;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_B_FRAC:
                begin
                    if (q_item.digit)
                    begin
                        seen_next = 1'b1;
                        if (pos_reg < 3'(LMP_FRAC_DIGITS))
                        begin
                            brg_next = acc_sat;
                            pos_next = pos_reg + 3'd1;
                        end
                    end
                    else if (!seen_reg)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        brg_next = brg_fin;
                        ok_next  = OK_BOTH;
                        pos_next = '0;
                        if (q_item.ws)
                        begin
                            phase_next = PH_LIT_PX;
                        end
                        else if (q_item.ch == CH_LC_P)
                        begin
                            phase_next = PH_LIT_PX;
                            pos_next   = 3'd1;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_LIT_PX:
                begin
                    if ((pos_reg == 3'd0) && q_item.ws)
                    begin
                        phase_next = PH_LIT_PX;
                    end
                    else if (lit_hit)
                    begin
                        pos_next = pos_reg + 3'd1;
                        if (pos_reg == 3'd2)
                        begin
                            phase_next = PH_PX_WS;
                            pos_next   = '0;
                            neg_next   = 1'b0;
                            seen_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_PX_WS:
                begin
                    if (q_item.ws)
                    begin
                        phase_next = PH_PX_WS;
                    end
                    else if (q_item.sign)
                    begin
                        neg_next   = q_item.minus;
                        phase_next = PH_PX_SIGN;
                    end
                    else if (q_item.digit)
                    begin
                        px_next    = digit_val;
                        seen_next  = 1'b1;
                        phase_next = PH_PX_DIG;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_PX_SIGN:
                begin
                    if (q_item.digit)
                    begin
                        px_next    = digit_val;
                        seen_next  = 1'b1;
                        phase_next = PH_PX_DIG;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_PX_DIG:
                begin
                    if (q_item.digit)
                    begin
                        px_next = acc_sat;
                    end
                    else
                    begin
                        px_next    = px_fin;
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (msg_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LM;
            pos_reg       <= '0;
            id_reg        <= '0;
            brg_reg       <= '0;
            px_reg        <= '0;
            neg_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            ok_reg        <= OK_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            id_reg        <= id_next;
            brg_reg       <= brg_next;
            px_reg        <= px_next;
            neg_reg       <= neg_next;
            seen_reg      <= seen_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_id_reg  <= eol_id;
            out_brg_reg <= eol_brg;
            out_px_reg  <= eol_px;
        end
    end

    assign msg_valid     = out_valid_reg;
    assign landmark_id   = $signed(out_id_reg);
    assign bearing_centi = $signed(out_brg_reg);
    assign pixel_size    = $signed(out_px_reg);

endmodule

FILE: hw/rtl/landmark_line_parser_core.sv
// Top level of the landmark line parser: front end, queue and parser back end.
// Throughput: one received byte per clock cycle, sustained, while results are taken.
// A line end request is written into the queue at the accepting edge, parsed from the
// queue head, and its message is then loaded into the output register; the parser
// takes one queue entry a cycle, and stalls only when a message is still held and a
// further line end arrives.
// Reset (rst_n low, asynchronous) clears the line counter, the queue and the parser state.
`timescale 1ns / 1ps

module landmark_line_parser_core #(
    parameter int MAX_LINE = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         rx_byte,
    input  logic               rx_valid,
    output logic               rx_ready,
    output logic signed [31:0] landmark_id,
    output logic signed [31:0] bearing_centi,
    output logic signed [31:0] pixel_size,
    output logic               msg_valid,
    input  logic               msg_ready
);
    import lmp_pkg::*;

    // The front end counts bytes of the current line, drops those past the limit and
    // empty line ends, and tags each kept request with its character class.
    lmp_item_t push_item;
    logic      push;
    logic      q_full;

    // The queue lets the front end keep accepting while the parser waits on the output.
    lmp_item_t head_item;
    logic      head_valid;
    logic      pop;

    lmp_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (rx_byte),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .q_full   (q_full),
        .q_push   (push),
        .q_item   (push_item)
    );

    lmp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // The back end walks the "LM:" id, "bearing:" decimal and "px:" fields of the line,
    // accumulating each number with a saturating multiply-by-ten, and at the line end
    // loads one message into its output register when the id and bearing both parsed.
    lmp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (head_valid),
        .q_item        (head_item),
        .q_pop         (pop),
        .landmark_id   (landmark_id),
        .bearing_centi (bearing_centi),
        .pixel_size    (pixel_size),
        .msg_valid     (msg_valid),
        .msg_ready     (msg_ready)
    );

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the landmark line parser core.
`timescale 1ns / 1ps

module tb;
    import lmp_pkg::*;

    localparam int LINE_LIMIT   = 128;
    localparam int ITEM_TARGET  = 1050;
    localparam int HOLD_OFF     = 500;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 300000;

    // Parser phases, following the order in which a line is read.
    typedef enum logic [3:0] {
        PH_LM, PH_ID_WS, PH_ID_SIGN, PH_ID_DIG, PH_LIT_B, PH_B_WS, PH_B_SIGN,
        PH_B_INT, PH_B_FRAC, PH_LIT_PX, PH_PX_WS, PH_PX_SIGN, PH_PX_DIG, PH_DONE
    } phase_e;

    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_PERIODIC, RDY_MOSTLY} ready_mode_e;

    typedef struct {
        logic signed [31:0] id;
        logic signed [31:0] bearing;
        logic signed [31:0] px;
    } landmark_msg_t;

    // Tracks the parse of the byte stream and holds the messages still owed by the block.
    class landmark_scoreboard;
        phase_e        phase;
        int            kept;
        int            pos;
        logic [31:0]   id_acc;
        logic [31:0]   brg_acc;
        logic [31:0]   px_acc;
        bit            neg;
        bit            seen;
        int            fields;
        landmark_msg_t owed[$];
        int            n_fail;
        int            n_bytes;
        int            n_lines;
        int            n_owed_total;
        int            n_checked;

        function new();
            clear_line();
            n_fail = 0;
            n_bytes = 0;
            n_lines = 0;
            n_owed_total = 0;
            n_checked = 0;
        endfunction

        function void clear_line();
            phase = PH_LM;
            kept = 0;
            pos = 0;
            id_acc = '0;
            brg_acc = '0;
            px_acc = '0;
            neg = 1'b0;
            seen = 1'b0;
            fields = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function bit is_space(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF ||
                   c == CH_LF || c == CH_CR;
        endfunction

        function bit is_num(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function logic [31:0] add_digit(logic [31:0] a, logic [7:0] c);
            logic [63:0] v;
            v = 64'(a) * 64'd10 + 64'(c - CH_ZERO);
            return (v > 64'(LMP_MAG_CAP)) ? LMP_MAG_CAP : v[31:0];
        endfunction

        // Turns a capped magnitude into the saturated signed value.
        function logic [31:0] apply_sign(logic [31:0] m, bit n);
            if (n)
            begin
                return 32'd0 - m;
            end
            return (m > LMP_POS_MAX) ? LMP_POS_MAX : m;
        endfunction

        function void close_id();
            id_acc = apply_sign(id_acc, neg);
            fields = 1;
        endfunction

        function void close_bearing();
            logic [31:0] m;
            m = brg_acc;
            for (int i = pos; i < LMP_FRAC_DIGITS; i++)
            begin
                m = add_digit(m, CH_ZERO);
            end
            brg_acc = apply_sign(m, neg);
            fields = 2;
        endfunction

        function int lit_len(phase_e p);
            return (p == PH_LIT_B) ? 8 : 3;
        endfunction

        function logic [7:0] lit_at(phase_e p, int i);
            case (p)
                PH_LM:
                begin
                    case (i)
                        0: return CH_UC_L;
                        1: return CH_UC_M;
                        default: return CH_COLON;
                    endcase
                end
                PH_LIT_B:
                begin
                    case (i)
                        0: return CH_LC_B;
                        1: return CH_LC_E;
                        2: return CH_LC_A;
                        3: return CH_LC_R;
                        4: return CH_LC_I;
                        5: return CH_LC_N;
                        6: return CH_LC_G;
                        default: return CH_COLON;
                    endcase
                end
                default:
                begin
                    case (i)
                        0: return CH_LC_P;
                        1: return CH_LC_X;
                        default: return CH_COLON;
                    endcase
                end
            endcase
        endfunction

        // Whitespace is allowed only ahead of the first character of the gap literals.
        function void match_literal(logic [7:0] c, bit gap, phase_e next_ph);
            if (gap && pos == 0 && is_space(c))
            begin
                return;
            end
            if (pos < lit_len(phase) && c == lit_at(phase, pos))
            begin
                pos++;
                if (pos == lit_len(phase))
                begin
                    phase = next_ph;
                    pos = 0;
                    neg = 1'b0;
                    seen = 1'b0;
                end
            end
            else
            begin
                phase = PH_DONE;
            end
        endfunction

        function void load_first(phase_e dig_ph, logic [7:0] c);
            case (dig_ph)
                PH_ID_DIG: id_acc = 32'(c - CH_ZERO);
                PH_B_INT:  brg_acc = 32'(c - CH_ZERO);
                default:   px_acc = 32'(c - CH_ZERO);
            endcase
            seen = 1'b1;
            phase = dig_ph;
        endfunction

        function void number_start(logic [7:0] c, phase_e sign_ph, phase_e dig_ph, bit dot_ok);
            if (is_space(c))
            begin
                return;
            end
            if (c == CH_PLUS || c == CH_MINUS)
            begin
                neg = (c == CH_MINUS);
                phase = sign_ph;
            end
            else if (is_num(c))
            begin
                load_first(dig_ph, c);
            end
            else if (dot_ok && c == CH_DOT)
            begin
                phase = PH_B_FRAC;
            end
            else
            begin
                phase = PH_DONE;
            end
        endfunction

        // A byte that ends the id or the bearing is read again in the literal phase that follows.
        function void parse_char(logic [7:0] c);
            bit again;
            again = 1'b1;
            while (again)
            begin
                again = 1'b0;
                case (phase)
                    PH_LM:    match_literal(c, 1'b0, PH_ID_WS);
                    PH_ID_WS: number_start(c, PH_ID_SIGN, PH_ID_DIG, 1'b0);
                    PH_ID_SIGN, PH_PX_SIGN:
                    begin
                        if (is_num(c))
                        begin
                            load_first((phase == PH_ID_SIGN) ? PH_ID_DIG : PH_PX_DIG, c);
                        end
                        else
                        begin
                            phase = PH_DONE;
                        end
                    end
                    PH_ID_DIG:
                    begin
                        if (is_num(c))
                        begin
                            id_acc = add_digit(id_acc, c);
                        end
                        else
                        begin
                            close_id();
                            phase = PH_LIT_B;
                            pos = 0;
                            again = 1'b1;
                        end
                    end
                    PH_LIT_B: match_literal(c, 1'b1, PH_B_WS);
                    PH_B_WS:  number_start(c, PH_B_SIGN, PH_B_INT, 1'b1);
                    PH_B_SIGN:
                    begin
                        if (is_num(c))
                        begin
                            load_first(PH_B_INT, c);
                        end
                        else if (c == CH_DOT)
                        begin
                            phase = PH_B_FRAC;
                        end
                        else
                        begin
                            phase = PH_DONE;
                        end
                    end
                    PH_B_INT:
                    begin
                        if (is_num(c))
                        begin
                            brg_acc = add_digit(brg_acc, c);
                        end
                        else if (c == CH_DOT)
                        begin
                            phase = PH_B_FRAC;
                        end
                        else
                        begin
                            close_bearing();
                            phase = PH_LIT_PX;
                            pos = 0;
                            again = 1'b1;
                        end
                    end
                    PH_B_FRAC:
                    begin
                        if (is_num(c))
                        begin
                            seen = 1'b1;
                            // Digits past the kept precision are dropped.
                            if (pos < LMP_FRAC_DIGITS)
                            begin
                                brg_acc = add_digit(brg_acc, c);
                                pos++;
                            end
                        end
                        else if (!seen)
                        begin
                            phase = PH_DONE;
                        end
                        else
                        begin
                            close_bearing();
                            phase = PH_LIT_PX;
                            pos = 0;
                            again = 1'b1;
                        end
                    end
                    PH_LIT_PX: match_literal(c, 1'b1, PH_PX_WS);
                    PH_PX_WS:  number_start(c, PH_PX_SIGN, PH_PX_DIG, 1'b0);
                    PH_PX_DIG:
                    begin
                        if (is_num(c))
                        begin
                            px_acc = add_digit(px_acc, c);
                        end
                        else
                        begin
                            px_acc = apply_sign(px_acc, neg);
                            phase = PH_DONE;
                        end
                    end
                    default: phase = PH_DONE;
                endcase
            end
        endfunction

        // Called for every accepted request on the byte channel.
        function void note_request(logic [7:0] c);
            landmark_msg_t m;
            if (c == CH_LF || c == CH_CR)
            begin
                if (kept == 0)
                begin
                    return;
                end
                n_bytes++;
                if (phase == PH_ID_DIG)
                begin
                    close_id();
                end
                else if ((phase == PH_B_INT || phase == PH_B_FRAC) && seen)
                begin
                    close_bearing();
                end
                else if (phase == PH_PX_DIG)
                begin
                    px_acc = apply_sign(px_acc, neg);
                end
                if (fields == 2)
                begin
                    m.id = id_acc;
                    m.bearing = brg_acc;
                    m.px = px_acc;
                    owed.push_back(m);
                    n_owed_total++;
                end
                n_lines++;
                clear_line();
                return;
            end
            n_bytes++;
            if (kept < LINE_LIMIT - 1)
            begin
                kept++;
                parse_char(c);
            end
        endfunction

        function void check_message(logic signed [31:0] id, logic signed [31:0] bearing,
                                    logic signed [31:0] px);
            landmark_msg_t m;
            if (owed.size() == 0)
            begin
                $error("unexpected message: landmark_id %0d bearing_centi %0d pixel_size %0d",
                       id, bearing, px);
                n_fail++;
                return;
            end
            m = owed.pop_front();
            n_checked++;
            if (id !== m.id)
            begin
                $error("landmark_id: expected %0d, got %0d", m.id, id);
                n_fail++;
            end
            if (bearing !== m.bearing)
            begin
                $error("bearing_centi: expected %0d, got %0d", m.bearing, bearing);
                n_fail++;
            end
            if (px !== m.px)
            begin
                $error("pixel_size: expected %0d, got %0d", m.px, px);
                n_fail++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic [7:0]         rx_byte;
    logic               rx_valid;
    logic               rx_ready;
    logic signed [31:0] landmark_id;
    logic signed [31:0] bearing_centi;
    logic signed [31:0] pixel_size;
    logic               msg_valid;
    logic               msg_ready;

    landmark_scoreboard sb = new();
    logic [7:0] line_buf[$];
    int burst_left = 0;
    int hold_cycles = 0;
    int cycle_count = 0;
    int input_stalls = 0;

    landmark_line_parser_core #(
        .MAX_LINE(LINE_LIMIT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .rx_byte(rx_byte),
        .rx_valid(rx_valid),
        .rx_ready(rx_ready),
        .landmark_id(landmark_id),
        .bearing_centi(bearing_centi),
        .pixel_size(pixel_size),
        .msg_valid(msg_valid),
        .msg_ready(msg_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (rx_valid && !rx_ready)
        begin
            input_stalls++;
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && msg_valid && msg_ready)
        begin
            sb.check_message(landmark_id, bearing_centi, pixel_size);
        end
    end

    // Message receiver: changing stall patterns, and a long hold-off when asked for.
    initial
    begin
        ready_mode_e mode;
        int left;
        int period;
        msg_ready = 1'b0;
        mode = RDY_ALWAYS;
        left = 0;
        period = 2;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                msg_ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = ready_mode_e'($urandom_range(0, 3));
                    left = $urandom_range(20, 150);
                    period = $urandom_range(2, 7);
                end
                left--;
                case (mode)
                    RDY_ALWAYS:   msg_ready <= 1'b1;
                    RDY_COIN:     msg_ready <= ($urandom_range(0, 1) == 1);
                    RDY_PERIODIC: msg_ready <= (left % period == 0);
                    default:      msg_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Each request is driven at a falling edge; bursts of random length are
    // separated by random gaps with valid low.
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        if (burst_left == 0)
        begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(60, 250)
                                                      : $urandom_range(1, 24);
        end
        rx_byte <= b;
        rx_valid <= 1'b1;
        @(posedge clk);
        while (!rx_ready)
        begin
            @(posedge clk);
        end
        sb.note_request(b);
        burst_left--;
    endtask

    task automatic send_line();
        foreach (line_buf[i])
        begin
            send_byte(line_buf[i]);
        end
    endtask

    // Stops offering requests and waits until every owed message has been taken.
    task automatic drain_all();
        @(negedge clk);
        rx_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void put_byte(logic [7:0] b);
        line_buf.push_back(b);
    endfunction

    function automatic void put(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            line_buf.push_back(s[i]);
        end
    endfunction

    task automatic send_text(string s, logic [7:0] eol);
        line_buf.delete();
        put(s);
        put_byte(eol);
        send_line();
    endtask

    function automatic void put_ws(int maxn);
        repeat ($urandom_range(0, maxn))
        begin
            case ($urandom_range(0, 5))
                0: put_byte(CH_TAB);
                1: put_byte(CH_VT);
                2: put_byte(CH_FF);
                default: put_byte(CH_SPACE);
            endcase
        end
    endfunction

    function automatic void put_sign();
        case ($urandom_range(0, 5))
            0: put_byte(CH_PLUS);
            1, 2: put_byte(CH_MINUS);
            default: ;
        endcase
    endfunction

    // Mostly short numbers; now and then long enough to saturate.
    function automatic void put_digits(int lo, int hi);
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(lo, hi);
        repeat (n)
        begin
            put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        end
    endfunction

    function automatic void put_decimal();
        case ($urandom_range(0, 3))
            0: put_digits(1, 4);
            1:
            begin
                put_digits(1, 4);
                put_byte(CH_DOT);
            end
            2:
            begin
                put_byte(CH_DOT);
                put_digits(1, 6);
            end
            default:
            begin
                put_digits(1, 4);
                put_byte(CH_DOT);
                put_digits(1, 6);
            end
        endcase
    endfunction

    function automatic void build_landmark_line();
        line_buf.delete();
        put("LM:");
        put_ws(2);
        put_sign();
        put_digits(1, 4);
        put_ws(2);
        put("bearing:");
        put_ws(2);
        put_sign();
        put_decimal();
        if ($urandom_range(0, 4) != 0)
        begin
            put_ws(2);
            put("px:");
            put_ws(2);
            put_sign();
            put_digits(1, 4);
            if ($urandom_range(0, 3) == 0)
            begin
                put(" ok");
            end
        end
    endfunction

    function automatic void put_eol();
        case ($urandom_range(0, 2))
            0: put_byte(CH_LF);
            1: put_byte(CH_CR);
            default:
            begin
                put_byte(CH_CR);
                put_byte(CH_LF);
            end
        endcase
    endfunction

    task automatic send_random_line();
        int sel;
        int cut;
        sel = $urandom_range(0, 99);
        if (sel < 60)
        begin
            build_landmark_line();
            if ($urandom_range(0, 7) == 0)
            begin
                line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
            end
        end
        else if (sel < 78)
        begin
            // Line cut short somewhere inside a well-formed record.
            build_landmark_line();
            cut = $urandom_range(0, line_buf.size() - 1);
            while (line_buf.size() > cut)
            begin
                void'(line_buf.pop_back());
            end
        end
        else if (sel < 92)
        begin
            line_buf.delete();
            repeat ($urandom_range(1, 30))
            begin
                put_byte(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            // Long line: any tail past the line limit must be dropped.
            build_landmark_line();
            repeat ($urandom_range(90, 150))
            begin
                put_byte(($urandom_range(0, 3) == 0) ? CH_SPACE : 8'($urandom_range(33, 126)));
            end
        end
        put_eol();
        send_line();
    endtask

    initial
    begin
        int rand_start;
        bit pressed;
        rst_n = 1'b0;
        rx_valid = 1'b0;
        rx_byte = '0;
        pressed = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed lines: extremes, the optional parts, and several ways a line can fail.
        send_text("LM:5 bearing:12.34 px:7", CH_LF);
        send_text("LM:0 bearing:-0 px:0", CH_LF);
        send_text("LM:-2147483648 bearing:-0.5 px:-3", CH_CR);
        send_text("LM:2147483647 bearing:21474836.47 px:-2147483648", CH_LF);
        send_text("LM:99999999999 bearing:99999999999 px:99999999999", CH_LF);
        send_text("LM:-99999999999 bearing:-21474836.48 px:+2147483648", CH_LF);
        line_buf.delete();
        put("LM:\t +12");
        put_byte(CH_VT);
        put_byte(CH_FF);
        put("bearing:\t.5\n");
        send_line();
        line_buf.delete();
        put("LM:3bearing:5.px:1");
        put_byte(CH_CR);
        put_byte(CH_LF);
        put_byte(CH_CR);
        put("\n");
        send_line();
        send_text("LM:3 bearing:1.23456 px:9", CH_LF);
        send_text(" LM:3 bearing:1 px:2", CH_LF);
        send_text("LM:+ bearing:1", CH_LF);
        send_text("LM:4 bearing:. px:1", CH_LF);
        send_text("LM:4 bearing:-.", CH_LF);
        send_text("LM:6 bearing:2e5 px:3", CH_LF);
        send_text("LM:7 bearing:8 px:1 trailing text", CH_LF);
        send_text("LM:8 bearing:9 px:+", CH_LF);
        send_text("LM:1 bearing:2 pq:3", CH_LF);
        send_text("LM:5\nLM:5 bearing:7", CH_LF);
        line_buf.delete();
        put("LM:1");
        put_byte(8'h00);
        put(" bearing:1\nLM:2 bearing:3");
        put_byte(8'h00);
        put("\n");
        send_line();
        line_buf.delete();
        put("LM:1 bearing:2 px:3");
        put_byte(8'hFF);
        put_byte(8'h80);
        put("\n");
        send_line();
        line_buf.delete();
        put("LM:1 bearing:2 px:3");
        repeat (150) put_byte(CH_LC_X);
        put("\n");
        send_line();
        // The px field falls just beyond the last kept byte.
        line_buf.delete();
        put("LM:1 bearing:2");
        repeat (113) put_byte(CH_SPACE);
        put("px:5\n");
        send_line();
        drain_all();

        rand_start = sb.n_bytes;
        while (sb.n_bytes - rand_start < ITEM_TARGET)
        begin
            if (!pressed && sb.n_bytes - rand_start > ITEM_TARGET / 2)
            begin
                // Long receiver hold-off while short records keep arriving, so the
                // message path fills and the byte channel has to stall.
                pressed = 1'b1;
                @(negedge clk);
                rx_valid <= 1'b0;
                hold_cycles = HOLD_OFF;
                repeat (8)
                begin
                    line_buf.delete();
                    put($sformatf("LM:%0d bearing:%0d.%0d px:%0d", $urandom_range(0, 999),
                                  $urandom_range(0, 359), $urandom_range(0, 99),
                                  $urandom_range(0, 99)));
                    put_byte(CH_LF);
                    send_line();
                end
                drain_all();
            end
            send_random_line();
        end
        drain_all();

        $display("Parsed %0d bytes over %0d lines; %0d landmark messages checked.",
                 sb.n_bytes, sb.n_lines, sb.n_checked);
        $display("Byte channel held back for %0d cycles by message back-pressure.",
                 input_stalls);
        if (sb.n_fail == 0 && sb.pending() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: landmark_line_parser_core.f
hw/rtl/lmp_pkg.sv
hw/rtl/lmp_front.sv
hw/rtl/lmp_queue.sv
hw/rtl/lmp_back.sv
hw/rtl/landmark_line_parser_core.sv
dv/tb.sv
